/* hw/rtl/bcm_lps_pkg.sv */
package bcm_lps_pkg;

    localparam int PLANES          = 8;
    localparam int WORDS_PER_PLANE = 16;
    localparam int SLOT_COUNT      = 12;
    localparam int COUNTER_TOP     = 1019;
    localparam int WORD_BITS       = 16;

    localparam int STORE_DEPTH = PLANES * WORDS_PER_PLANE;
    localparam int PLANE_BITS  = WORDS_PER_PLANE * WORD_BITS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int POS_W       = $clog2(PLANE_BITS + 1);
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int PLANE_W     = 3;
    localparam int SLOT_W      = 4;
    localparam int CNT_W       = 10;
    localparam int WIDX_W      = 4;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_SHIFT = 2'd2;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [PLANE_W-1:0] plane_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [BIT_W-1:0]   bit_idx_t;

    typedef struct packed {
        logic     latch;
        logic     shift_ok;
        logic     last;
        addr_t    rd_addr;
        bit_idx_t bit_idx;
        slot_t    slot_now;
        plane_t   plane_shown;
    } sched_res_t;

    function automatic logic [CNT_W-1:0] slot_end(input slot_t idx);
        logic [CNT_W-1:0] v;
        unique case (idx)
            4'd0:    v = 10'd127;
            4'd1:    v = 10'd131;
            4'd2:    v = 10'd259;
            4'd3:    v = 10'd267;
            4'd4:    v = 10'd395;
            4'd5:    v = 10'd411;
            4'd6:    v = 10'd539;
            4'd7:    v = 10'd571;
            4'd8:    v = 10'd699;
            4'd9:    v = 10'd763;
            4'd10:   v = 10'd891;
            4'd11:   v = 10'd1019;
            default: v = 10'd1019;
        endcase
        return v;
    endfunction

    function automatic plane_t slot_plane(input slot_t idx);
        plane_t p;
        unique case (idx)
            4'd0:    p = 3'd7;
            4'd1:    p = 3'd0;
            4'd2:    p = 3'd6;
            4'd3:    p = 3'd1;
            4'd4:    p = 3'd7;
            4'd5:    p = 3'd2;
            4'd6:    p = 3'd6;
            4'd7:    p = 3'd3;
            4'd8:    p = 3'd7;
            4'd9:    p = 3'd4;
            4'd10:   p = 3'd7;
            4'd11:   p = 3'd5;
            default: p = 3'd5;
        endcase
        return p;
    endfunction

    function automatic slot_t slot_inc(input slot_t idx);
        return (idx == slot_t'(SLOT_COUNT - 1)) ? '0 : slot_t'(idx + 1'b1);
    endfunction

endpackage

/* hw/rtl/bcm_led_plane_scheduler.sv */
// LED bit-plane scheduler for a shift-register chain.
// Slave side: one request per accepted beat; s_tuser is the action
// (tick, frame-word write, shift one bit), s_tdata carries plane, word and
// value for writes. Master side: exactly one response per request, in order:
// m_tdata holds latch pulse, serial bit, current slot and plane shown,
// m_tuser marks a real serial bit, m_tlast the final bit of a plane.
// cfg_we/cfg_wdata set the run flag; only while running do ticks advance
// the slot timer.
// Each response passes two registered stages: the frame-store read, then
// the output register. Throughput: one request per cycle while m_tready
// is high; each needs at most one read or one write of the frame store.
// Reset: run flag cleared, slot 0, timer 0, shifting ready on plane 0, and
// every frame word reads as 0xFFFF until first written (no sweep needed).
// When m_tready is low the two stages fill and s_tready drops; no request
// is lost or repeated.
module bcm_led_plane_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // plane_index[2:0], word_index[6:3], word_value[22:7]
    input  logic [1:0]  s_tuser,   // action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // latch_pulse[0], serial_bit[1], slot_now[5:2],
                                   // plane_shown[8:6]
    output logic        m_tuser,   // bit_valid
    output logic        m_tlast    // last_bit
);
    import bcm_lps_pkg::*;

    logic       run_reg;
    logic       accept;
    logic       s1_adv;
    sched_res_t res;
    logic [15:0] rd_word;
    logic       wr_en;
    addr_t      wr_addr;

    logic       s1_valid_reg;
    sched_res_t s1_reg;
    logic       s2_valid_reg;
    logic       s2_latch_reg, s2_bit_reg, s2_ok_reg, s2_last_reg;
    slot_t      s2_slot_reg;
    plane_t     s2_plane_reg;

    assign s1_adv   = !s2_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            run_reg <= cfg_wdata;
        end
    end

    bcm_sched u_sched (
        .clk        (clk),
        .rst_n      (rst_n),
        .run_enable (run_reg),
        .accept     (accept),
        .action     (s_tuser),
        .res        (res)
    );

    assign wr_en   = accept && (s_tuser == ACT_WRITE)
                     && (32'(s_tdata[6:3]) < WORDS_PER_PLANE);
    assign wr_addr = addr_t'(ADDR_W'(s_tdata[2:0]) * ADDR_W'(WORDS_PER_PLANE)
                             + ADDR_W'(s_tdata[6:3]));

    bcm_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_tdata[22:7]),
        .re    (accept && res.shift_ok),
        .raddr (res.rd_addr),
        .rdata (rd_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (s1_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= res;
        end
        if (s1_adv && s1_valid_reg)
        begin
            s2_latch_reg <= s1_reg.latch;
            s2_bit_reg   <= s1_reg.shift_ok && rd_word[s1_reg.bit_idx];
            s2_ok_reg    <= s1_reg.shift_ok;
            s2_last_reg  <= s1_reg.last;
            s2_slot_reg  <= s1_reg.slot_now;
            s2_plane_reg <= s1_reg.plane_shown;
        end
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {7'd0, s2_plane_reg, s2_slot_reg, s2_bit_reg, s2_latch_reg};
    assign m_tuser  = s2_ok_reg;
    assign m_tlast  = s2_last_reg;

    a_last_is_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last bit without a valid bit");

    a_no_latch_and_bit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tuser))
        else $error("latch pulse and serial bit in one response");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[5:2] <= 4'd11))
        else $error("slot index out of schedule");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_reg))
        else $error("stalled request lost in read stage");

    a_bit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> !m_tdata[1])
        else $error("serial bit set without valid");

endmodule

/* hw/rtl/bcm_ram.sv */
module bcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/bcm_store.sv */
module bcm_store (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   we,
    input  bcm_lps_pkg::addr_t     waddr,
    input  logic [15:0]            wdata,
    input  logic                   re,
    input  bcm_lps_pkg::addr_t     raddr,
    output logic [15:0]            rdata
);
    import bcm_lps_pkg::*;

    // unwritten words read as all ones (LEDs off)
    logic [STORE_DEPTH-1:0] written_reg;
    logic                   rd_written_reg;
    logic [15:0]            ram_rdata;

    bcm_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                written_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_written_reg <= written_reg[raddr];
            end
        end
    end

    assign rdata = rd_written_reg ? ram_rdata : '1;

endmodule

/* hw/rtl/bcm_sched.sv */
module bcm_sched (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    run_enable,
    input  logic                    accept,
    input  logic [1:0]              action,
    output bcm_lps_pkg::sched_res_t res
);
    import bcm_lps_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    slot_t            slot_reg, slot_next;
    plane_t           plane_reg, plane_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    always_comb
    begin
        cnt_next       = cnt_reg;
        slot_next      = slot_reg;
        plane_next     = plane_reg;
        pos_next       = pos_reg;
        res.latch      = 1'b0;
        res.shift_ok   = 1'b0;
        res.last       = 1'b0;
        res.rd_addr    = addr_t'(ADDR_W'(plane_reg) * ADDR_W'(WORDS_PER_PLANE)
                                 + ADDR_W'(pos_reg >> BIT_W));
        res.bit_idx    = pos_reg[BIT_W-1:0];
        unique case (action)
            ACT_TICK:
            begin
                if (run_enable)
                begin
                    if (cnt_reg == slot_end(slot_reg))
                    begin
                        res.latch  = 1'b1;
                        slot_next  = slot_inc(slot_reg);
                        plane_next = slot_plane(slot_inc(slot_next));
                        pos_next   = '0;
                    end
                    cnt_next = (cnt_reg >= CNT_W'(COUNTER_TOP)) ? '0 : cnt_reg + 1'b1;
                end
            end
            ACT_SHIFT:
            begin
                if (pos_reg < POS_W'(PLANE_BITS))
                begin
                    res.shift_ok = 1'b1;
                    res.last     = (pos_reg == POS_W'(PLANE_BITS - 1));
                    pos_next     = pos_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        res.slot_now    = slot_next;
        res.plane_shown = slot_plane(slot_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            slot_reg  <= '0;
            plane_reg <= slot_plane(slot_t'(1));
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            cnt_reg   <= cnt_next;
            slot_reg  <= slot_next;
            plane_reg <= plane_next;
            pos_reg   <= pos_next;
        end
    end

endmodule
